// ----- src/dtma_pkg.sv -----
// Shared types and constants for the debug transmit merge arbiter.
package dtma_pkg;

    // Default queue depths.
    localparam int MAIN_DEPTH_DEF = 1024;
    localparam int PRIO_DEPTH_DEF = 64;

    // Request codes.
    localparam logic [1:0] REQ_PUSH_MAIN = 2'd0;
    localparam logic [1:0] REQ_PUSH_PRIO = 2'd1;
    localparam logic [1:0] REQ_SLOT      = 2'd2;

    // Line phase codes of the transmit sequencer.
    localparam logic [2:0] PH_MAIN  = 3'd0;
    localparam logic [2:0] PH_CHECK = 3'd1;
    localparam logic [2:0] PH_DRAIN = 3'd2;
    localparam logic [2:0] PH_LF    = 3'd3;
    localparam logic [2:0] PH_CR    = 3'd4;

    // Framing characters.
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // One input transfer.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } t_req_in;

    // One result transfer.
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        push_accepted;
        logic [10:0] main_level;
        logic [31:0] main_drops;
        logic [31:0] priority_drops;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } t_cmd;

endpackage

// ----- src/dtma_ctrl.sv -----
// Controller state machine that sequences load, memory read and execute.
module dtma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output dtma_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;

    // Commands decoded from the current state.
    assign o_busy     = (r_state != S_IDLE);
    assign o_cmd.load = i_start && (r_state == S_IDLE);
    assign o_cmd.rd   = (r_state == S_READ);
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_done     = r_done;

    // Next state.
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_start ? S_READ : S_IDLE;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State and result strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.exec;
        end
    end

    // A result strobe always follows an execute cycle.
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without execute cycle");

    // An accepted transfer walks through read and execute.
    a_load_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_READ) ##1 (r_state == S_EXEC))
        else $error("load did not reach read and execute");

    // The block is ready again while the result is shown.
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("busy while result is shown");

endmodule

// ----- src/dtma_dp.sv -----
// Datapath: both byte queues, the line phase sequencer and the drop counters.
module dtma_dp #(
    parameter int MAIN_DEPTH = dtma_pkg::MAIN_DEPTH_DEF,
    parameter int PRIO_DEPTH = dtma_pkg::PRIO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtma_pkg::t_cmd    i_cmd,
    input  dtma_pkg::t_req_in i_req,
    output dtma_pkg::t_result o_result
);

    localparam int MAW = $clog2(MAIN_DEPTH);
    localparam int MCW = $clog2(MAIN_DEPTH + 1);
    localparam int PAW = $clog2(PRIO_DEPTH);
    localparam int PCW = $clog2(PRIO_DEPTH + 1);

    // Queue storage.
    logic [7:0] main_mem [MAIN_DEPTH];
    logic [7:0] prio_mem [PRIO_DEPTH];

    dtma_pkg::t_req_in r_req;
    dtma_pkg::t_result r_res;
    dtma_pkg::t_result n_res;
    logic [7:0]  r_main_q;
    logic [7:0]  r_prio_q;

    logic [MAW-1:0] r_main_head, n_main_head, r_main_tail, n_main_tail;
    logic [MCW-1:0] r_main_count, n_main_count;
    logic [PAW-1:0] r_prio_head, n_prio_head, r_prio_tail, n_prio_tail;
    logic [PCW-1:0] r_prio_count, n_prio_count;
    logic [2:0]     r_phase, n_phase;
    logic           r_line_end, n_line_end;
    logic [31:0]    r_main_drops, n_main_drops;
    logic [31:0]    r_prio_drops, n_prio_drops;
    logic           main_we;
    logic           prio_we;

    // Next state and result of the current request.
    always_comb begin
        n_main_head  = r_main_head;
        n_main_tail  = r_main_tail;
        n_main_count = r_main_count;
        n_prio_head  = r_prio_head;
        n_prio_tail  = r_prio_tail;
        n_prio_count = r_prio_count;
        n_phase      = r_phase;
        n_line_end   = r_line_end;
        n_main_drops = r_main_drops;
        n_prio_drops = r_prio_drops;
        main_we      = 1'b0;
        prio_we      = 1'b0;
        n_res.tx_valid      = 1'b0;
        n_res.tx_byte       = 8'd0;
        n_res.push_accepted = 1'b0;

        unique case (r_req.req_type)
            dtma_pkg::REQ_PUSH_MAIN: begin
                if (r_main_count != MCW'(MAIN_DEPTH)) begin
                    main_we             = 1'b1;
                    n_main_head         = (r_main_head == MAW'(MAIN_DEPTH - 1)) ?
                                          '0 : r_main_head + 1'b1;
                    n_main_count        = r_main_count + 1'b1;
                    n_res.push_accepted = 1'b1;
                end else begin
                    n_main_drops = r_main_drops + 32'd1;
                end
            end
            dtma_pkg::REQ_PUSH_PRIO: begin
                if (r_prio_count != PCW'(PRIO_DEPTH)) begin
                    prio_we             = 1'b1;
                    n_prio_head         = (r_prio_head == PAW'(PRIO_DEPTH - 1)) ?
                                          '0 : r_prio_head + 1'b1;
                    n_prio_count        = r_prio_count + 1'b1;
                    n_res.push_accepted = 1'b1;
                end else begin
                    n_prio_drops = r_prio_drops + 32'd1;
                end
            end
            dtma_pkg::REQ_SLOT: begin
                // Transmit slot: the line phase decides what goes out.
                unique case (r_phase)
                    dtma_pkg::PH_MAIN: begin
                        if (r_main_count != '0) begin
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = r_main_q;
                            n_main_tail    = (r_main_tail == MAW'(MAIN_DEPTH - 1)) ?
                                             '0 : r_main_tail + 1'b1;
                            n_main_count   = r_main_count - 1'b1;
                            n_line_end     = (r_main_q == dtma_pkg::CH_CR);
                        end else begin
                            n_phase = r_line_end ? dtma_pkg::PH_CHECK : dtma_pkg::PH_MAIN;
                        end
                    end
                    dtma_pkg::PH_CHECK: begin
                        if (r_prio_count != '0) begin
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = dtma_pkg::CH_STAR;
                            n_phase        = dtma_pkg::PH_DRAIN;
                        end else begin
                            n_phase = dtma_pkg::PH_MAIN;
                        end
                    end
                    dtma_pkg::PH_DRAIN: begin
                        if (r_prio_count != '0) begin
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = r_prio_q;
                            n_prio_tail    = (r_prio_tail == PAW'(PRIO_DEPTH - 1)) ?
                                             '0 : r_prio_tail + 1'b1;
                            n_prio_count   = r_prio_count - 1'b1;
                        end else begin
                            n_phase = dtma_pkg::PH_LF;
                        end
                    end
                    dtma_pkg::PH_LF: begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = dtma_pkg::CH_LF;
                        n_phase        = dtma_pkg::PH_CR;
                    end
                    dtma_pkg::PH_CR: begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = dtma_pkg::CH_CR;
                        n_phase        = dtma_pkg::PH_MAIN;
                    end
                    default: begin
                        n_phase = dtma_pkg::PH_MAIN;
                    end
                endcase
            end
            default: begin
                // Unused request code: status only.
            end
        endcase

        n_res.main_level     = 11'(n_main_count);
        n_res.main_drops     = n_main_drops;
        n_res.priority_drops = n_prio_drops;
    end

    // Request capture, queue memories with registered read data, result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec && main_we) begin
            main_mem[r_main_head] <= r_req.data_byte;
        end
        if (i_cmd.exec && prio_we) begin
            prio_mem[r_prio_head] <= r_req.data_byte;
        end
        if (i_cmd.rd) begin
            r_main_q <= main_mem[r_main_tail];
            r_prio_q <= prio_mem[r_prio_tail];
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    // Queue pointers, line phase and drop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_head  <= '0;
            r_main_tail  <= '0;
            r_main_count <= '0;
            r_prio_head  <= '0;
            r_prio_tail  <= '0;
            r_prio_count <= '0;
            r_phase      <= dtma_pkg::PH_CHECK;
            r_line_end   <= 1'b1;
            r_main_drops <= '0;
            r_prio_drops <= '0;
        end else if (i_cmd.exec) begin
            r_main_head  <= n_main_head;
            r_main_tail  <= n_main_tail;
            r_main_count <= n_main_count;
            r_prio_head  <= n_prio_head;
            r_prio_tail  <= n_prio_tail;
            r_prio_count <= n_prio_count;
            r_phase      <= n_phase;
            r_line_end   <= n_line_end;
            r_main_drops <= n_main_drops;
            r_prio_drops <= n_prio_drops;
        end
    end

    assign o_result = r_res;

    // Fill levels never pass the queue depths.
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_count <= MCW'(MAIN_DEPTH)) && (r_prio_count <= PCW'(PRIO_DEPTH)))
        else $error("queue level beyond depth");

    // The sequencer stays among its five phases.
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= dtma_pkg::PH_CR)
        else $error("line phase out of range");

    // Only a transmit slot sends a byte.
    a_tx_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_req.req_type != dtma_pkg::REQ_SLOT)) |=> !r_res.tx_valid)
        else $error("byte sent outside a transmit slot");

endmodule

// ----- src/debug_tx_merge_arbiter.sv -----
// Top level of the debug transmit merge arbiter: controller plus datapath.
// A result strobe o_done follows the start transfer through the memory read and execute states.
// A new request is taken only while idle; busy covers the memory read and execute states.
// The queue memories have one registered read port, which sets the read cycle.
// Reset (synchronous, active low) empties both queues, clears the drop counters
// and puts the sequencer at a line boundary; the receiver cannot stall results.
module debug_tx_merge_arbiter #(
    parameter int MAIN_DEPTH = dtma_pkg::MAIN_DEPTH_DEF,
    parameter int PRIO_DEPTH = dtma_pkg::PRIO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dtma_pkg::t_req_in i_req,
    output logic              busy,
    output logic              o_done,
    output dtma_pkg::t_result o_result
);

    dtma_pkg::t_cmd cmd;

    // Sequencing.
    dtma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Queues and transmit logic.
    dtma_dp #(
        .MAIN_DEPTH (MAIN_DEPTH),
        .PRIO_DEPTH (PRIO_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

endmodule
